// ===== rtl/core/shnk_pkg.sv =====
// ----------------------------------------------------------------------------
// shnk_pkg: shared definitions for the spatial hash neighbor key core
// Widths, operation and register codes, lane types and the step functions
// of the bucket divider and the resolution wrap.
// ----------------------------------------------------------------------------
package shnk_pkg;

   localparam int unsigned WORD_W     = 32;
   localparam int unsigned RES_W      = 11;
   localparam int unsigned IDX_W      = 10;
   localparam int unsigned KEY_W      = 30;
   localparam int unsigned OP_W       = 2;
   localparam int unsigned NB_W       = 3;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned AXES       = 3;

   localparam int unsigned DIV_STAGES = 32;
   localparam int unsigned MOD_BITS   = 4;
   localparam int unsigned MOD_STAGES = WORD_W / MOD_BITS;

   localparam logic [OP_W-1:0] OP_POS_KEY   = 2'd0;
   localparam logic [OP_W-1:0] OP_NEAR_KEYS = 2'd1;
   localparam logic [OP_W-1:0] OP_CELL_KEY  = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE      = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_SPACING = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RES_X   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RES_Y   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RES_Z   = 2'd3;

   localparam logic [WORD_W-1:0] SPACING_RESET = 32'd65536;
   localparam logic [RES_W-1:0]  RES_RESET     = 11'd64;
   localparam logic [RES_W-1:0]  RES_MAX       = 11'd1024;

   localparam logic [NB_W-1:0] NB_LAST = 3'd7;

   typedef struct packed {
      logic [WORD_W-1:0] rem;
      logic [WORD_W-1:0] num;
   } div_lane_type;

   typedef struct packed {
      logic [IDX_W-1:0]  rem;
      logic [WORD_W-1:0] num;
   } mod_lane_type;

   // One restoring division step: one quotient bit shifts into num.
   function automatic div_lane_type div_step(div_lane_type l, logic [WORD_W:0] s);
      logic [WORD_W:0] t;
      div_lane_type    r;
      t     = {l.rem, l.num[WORD_W-1]};
      r.num = {l.num[WORD_W-2:0], 1'b0};
      if (t >= s) begin
         r.rem    = WORD_W'(t - s);
         r.num[0] = 1'b1;
      end else begin
         r.rem = t[WORD_W-1:0];
      end
      return r;
   endfunction

   // MOD_BITS remainder steps against a resolution of at most 1024.
   function automatic mod_lane_type mod_step(mod_lane_type l, logic [RES_W-1:0] res);
      logic [RES_W-1:0] t;
      mod_lane_type     r;
      r = l;
      for (int i = 0; i < MOD_BITS; i++) begin
         t     = {r.rem, r.num[WORD_W-1]};
         r.num = {r.num[WORD_W-2:0], 1'b0};
         if (t >= res) begin
            t = t - res;
         end
         r.rem = t[IDX_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/spatial_hash_neighbor_keys_core.sv =====
// ----------------------------------------------------------------------------
// spatial_hash_neighbor_keys_core: uniform 3D grid hash key generator
// Turns a Q16.16 point or a bucket index into wrapped, z-major linear keys.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   operation, pos_x/y/z, cell_x/y/z
//   rsp      out        rsp_valid/rsp_stall   key, neighbor_number, last
//   csr      in         csr_write             csr_index, csr_data
//
// Key-from-position and key-from-index words enter and leave one per cycle
// unless stalled; a nearby-keys word holds the expander for its eight keys.
// Behind the input register come 32 divider stages, the fix-up register,
// 8 wrap stages and five more registers (wrapped index, expander, two
// multiply, out) before the result reaches the port.
// Reset is synchronous and clears valid bits, expander state and settings.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.
//
// Operation codes: key from position, eight nearby keys, key from bucket
// index; the fourth code produces no result and is dropped at the expander.
//
// The pipeline runs in four sections. First, a restoring divider takes one
// quotient bit per stage for each axis, giving |pos| / spacing. Second, a
// fix-up register turns this into the floor quotient, decides on which side
// of the bucket center the point lies, and picks the bucket index itself
// for index queries. Third, the wrap divider reduces the index modulo the
// axis resolution, four bits per stage. Fourth, the expander produces one
// index triple per unstalled cycle and two multiply stages build the linear key.
//
// The neighbor index along an axis is the wrapped origin stepped by one and
// wrapped again. When the step would leave the signed 32-bit range, the
// saturated neighbor equals the origin, so the origin is used unchanged.

module spatial_hash_neighbor_keys_core
   import shnk_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [OP_W-1:0]       req_operation,
   input  logic signed [WORD_W-1:0] req_pos_x,
   input  logic signed [WORD_W-1:0] req_pos_y,
   input  logic signed [WORD_W-1:0] req_pos_z,
   input  logic signed [WORD_W-1:0] req_cell_x,
   input  logic signed [WORD_W-1:0] req_cell_y,
   input  logic signed [WORD_W-1:0] req_cell_z,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [KEY_W-1:0]      rsp_key,
   output logic [NB_W-1:0]       rsp_neighbor_number,
   output logic                  rsp_last,

   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [WORD_W-1:0]     csr_data
);

   // Configuration, stored already clamped: zero spacing reads as one and
   // each resolution is held in the range 1 to 1024.
   logic [WORD_W-1:0] spacing_ff;
   logic [RES_W-1:0]  res_ff [AXES];
   logic [RES_W-1:0]  res_in;
   logic [WORD_W:0]   spacing_w;

   always_comb begin
      if (csr_data[RES_W-1:0] == '0) begin
         res_in = RES_W'(1);
      end else if (csr_data[RES_W-1:0] > RES_MAX) begin
         res_in = RES_MAX;
      end else begin
         res_in = csr_data[RES_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_ff <= SPACING_RESET;
         for (int a = 0; a < AXES; a++) begin
            res_ff[a] <= RES_RESET;
         end
      end else if (csr_write) begin
         case (csr_index)
            CSR_SPACING: spacing_ff <= (csr_data == '0) ? WORD_W'(1) : csr_data;
            CSR_RES_X:   res_ff[0]  <= res_in;
            CSR_RES_Y:   res_ff[1]  <= res_in;
            CSR_RES_Z:   res_ff[2]  <= res_in;
            default:     spacing_ff <= spacing_ff;
         endcase
      end
   end

   assign spacing_w = {1'b0, spacing_ff};

   // The output register advances when it is empty or being taken. The
   // front sections also wait while the expander still owes neighbor keys.
   logic       adv;
   logic       front_adv;
   logic       ex_valid_ff;
   logic       ex_multi_ff;
   logic [NB_W-1:0] ex_cnt_ff;
   logic       ex_hold;

   assign adv       = !(rsp_valid && rsp_stall);
   assign ex_hold   = ex_valid_ff && ex_multi_ff && (ex_cnt_ff != NB_LAST);
   assign front_adv = adv && !ex_hold;
   assign req_stall = !front_adv;

   // ---------------- bucket divider ----------------
   logic                         dv_valid_ff [DIV_STAGES+1];
   logic [OP_W-1:0]              dv_op_ff    [DIV_STAGES+1];
   logic [AXES-1:0]              dv_neg_ff   [DIV_STAGES+1];
   logic [AXES-1:0][WORD_W-1:0]  dv_cell_ff  [DIV_STAGES+1];
   div_lane_type [AXES-1:0]      dv_lane_ff  [DIV_STAGES+1];
   logic [AXES-1:0][WORD_W-1:0]  req_pos;

   assign req_pos = {req_pos_z, req_pos_y, req_pos_x};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= DIV_STAGES; s++) begin
            dv_valid_ff[s] <= 1'b0;
         end
      end else if (front_adv) begin
         dv_valid_ff[0] <= req_valid;
         for (int s = 1; s <= DIV_STAGES; s++) begin
            dv_valid_ff[s] <= dv_valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (front_adv) begin
         dv_op_ff[0]   <= req_operation;
         dv_cell_ff[0] <= {req_cell_z, req_cell_y, req_cell_x};
         for (int a = 0; a < AXES; a++) begin
            dv_neg_ff[0][a]      <= req_pos[a][WORD_W-1];
            dv_lane_ff[0][a].rem <= '0;
            dv_lane_ff[0][a].num <= req_pos[a][WORD_W-1] ? (~req_pos[a] + WORD_W'(1))
                                                         : req_pos[a];
         end
         for (int s = 1; s <= DIV_STAGES; s++) begin
            dv_op_ff[s]   <= dv_op_ff[s-1];
            dv_neg_ff[s]  <= dv_neg_ff[s-1];
            dv_cell_ff[s] <= dv_cell_ff[s-1];
            for (int a = 0; a < AXES; a++) begin
               dv_lane_ff[s][a] <= div_step(dv_lane_ff[s-1][a], spacing_w);
            end
         end
      end
   end

   // ---------------- floor fix-up and index select ----------------
   logic [AXES-1:0][WORD_W-1:0] fx_val;
   logic [AXES-1:0]             fx_up;
   logic [AXES-1:0]             fx_sat;

   always_comb begin
      logic [WORD_W-1:0] q;
      logic [WORD_W-1:0] r;
      logic [WORD_W-1:0] qm;
      logic [WORD_W-1:0] rm;
      for (int a = 0; a < AXES; a++) begin
         qm = dv_lane_ff[DIV_STAGES][a].num;
         rm = dv_lane_ff[DIV_STAGES][a].rem;
         if (dv_neg_ff[DIV_STAGES][a]) begin
            if (rm != '0) begin
               q = ~qm;
               r = WORD_W'(spacing_w - {1'b0, rm});
            end else begin
               q = ~qm + WORD_W'(1);
               r = '0;
            end
         end else begin
            q = qm;
            r = rm;
         end
         fx_up[a]  = ({1'b0, r, 1'b0} >= {1'b0, spacing_w});
         fx_sat[a] = fx_up[a] ? (q == 32'h7FFF_FFFF) : (q == 32'h8000_0000);
         fx_val[a] = (dv_op_ff[DIV_STAGES] == OP_CELL_KEY) ? dv_cell_ff[DIV_STAGES][a] : q;
      end
   end

   // ---------------- wrap divider ----------------
   logic                    md_valid_ff [MOD_STAGES+1];
   logic [OP_W-1:0]         md_op_ff    [MOD_STAGES+1];
   logic [AXES-1:0]         md_neg_ff   [MOD_STAGES+1];
   logic [AXES-1:0]         md_up_ff    [MOD_STAGES+1];
   logic [AXES-1:0]         md_sat_ff   [MOD_STAGES+1];
   mod_lane_type [AXES-1:0] md_lane_ff  [MOD_STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= MOD_STAGES; s++) begin
            md_valid_ff[s] <= 1'b0;
         end
      end else if (front_adv) begin
         md_valid_ff[0] <= dv_valid_ff[DIV_STAGES];
         for (int s = 1; s <= MOD_STAGES; s++) begin
            md_valid_ff[s] <= md_valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (front_adv) begin
         md_op_ff[0]  <= dv_op_ff[DIV_STAGES];
         md_up_ff[0]  <= fx_up;
         md_sat_ff[0] <= fx_sat;
         for (int a = 0; a < AXES; a++) begin
            md_neg_ff[0][a]      <= fx_val[a][WORD_W-1];
            md_lane_ff[0][a].rem <= '0;
            md_lane_ff[0][a].num <= fx_val[a][WORD_W-1] ? (~fx_val[a] + WORD_W'(1))
                                                        : fx_val[a];
         end
         for (int s = 1; s <= MOD_STAGES; s++) begin
            md_op_ff[s]  <= md_op_ff[s-1];
            md_up_ff[s]  <= md_up_ff[s-1];
            md_sat_ff[s] <= md_sat_ff[s-1];
            md_neg_ff[s] <= md_neg_ff[s-1];
            for (int a = 0; a < AXES; a++) begin
               md_lane_ff[s][a] <= mod_step(md_lane_ff[s-1][a], res_ff[a]);
            end
         end
      end
   end

   // ---------------- wrapped origin and neighbor ----------------
   logic [IDX_W-1:0] wr_org_in [AXES];
   logic [IDX_W-1:0] wr_nbr_in [AXES];
   logic             wr_valid_ff;
   logic [OP_W-1:0]  wr_op_ff;
   logic [IDX_W-1:0] wr_org_ff [AXES];
   logic [IDX_W-1:0] wr_nbr_ff [AXES];

   always_comb begin
      logic [IDX_W-1:0] m;
      logic [RES_W-1:0] w;
      for (int a = 0; a < AXES; a++) begin
         m = md_lane_ff[MOD_STAGES][a].rem;
         if (md_neg_ff[MOD_STAGES][a] && (m != '0)) begin
            w = res_ff[a] - {1'b0, m};
         end else begin
            w = {1'b0, m};
         end
         wr_org_in[a] = w[IDX_W-1:0];
         if (md_sat_ff[MOD_STAGES][a]) begin
            wr_nbr_in[a] = w[IDX_W-1:0];
         end else if (md_up_ff[MOD_STAGES][a]) begin
            wr_nbr_in[a] = (w + RES_W'(1) == res_ff[a]) ? '0 : IDX_W'(w + RES_W'(1));
         end else begin
            wr_nbr_in[a] = (w == '0) ? IDX_W'(res_ff[a] - RES_W'(1)) : IDX_W'(w - RES_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_valid_ff <= 1'b0;
      end else if (front_adv) begin
         wr_valid_ff <= md_valid_ff[MOD_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (front_adv) begin
         wr_op_ff <= md_op_ff[MOD_STAGES];
         for (int a = 0; a < AXES; a++) begin
            wr_org_ff[a] <= wr_org_in[a];
            wr_nbr_ff[a] <= wr_nbr_in[a];
         end
      end
   end

   // ---------------- expander ----------------
   // Holds one word and hands out one index triple per cycle unless stalled:
   // one for position and index queries, eight for a nearby-keys query.
   logic [IDX_W-1:0] ex_org_ff [AXES];
   logic [IDX_W-1:0] ex_nbr_ff [AXES];

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff <= 1'b0;
         ex_multi_ff <= 1'b0;
         ex_cnt_ff   <= '0;
      end else if (adv) begin
         if (ex_hold) begin
            ex_cnt_ff <= ex_cnt_ff + NB_W'(1);
         end else begin
            ex_valid_ff <= wr_valid_ff && (wr_op_ff != OP_NONE);
            ex_multi_ff <= (wr_op_ff == OP_NEAR_KEYS);
            ex_cnt_ff   <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && !ex_hold) begin
         for (int a = 0; a < AXES; a++) begin
            ex_org_ff[a] <= wr_org_ff[a];
            ex_nbr_ff[a] <= wr_nbr_ff[a];
         end
      end
   end

   // ---------------- key build ----------------
   logic             m1_valid_ff;
   logic [IDX_W-1:0] m1_idx_ff [AXES];
   logic [NB_W-1:0]  m1_nb_ff;
   logic             m1_last_ff;
   logic             m2_valid_ff;
   logic [19:0]      m2_part_ff;
   logic [IDX_W-1:0] m2_x_ff;
   logic [NB_W-1:0]  m2_nb_ff;
   logic             m2_last_ff;
   logic             rsp_valid_ff;
   logic [KEY_W-1:0] rsp_key_ff;
   logic [NB_W-1:0]  rsp_nb_ff;
   logic             rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff  <= 1'b0;
         m2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         m1_valid_ff  <= ex_valid_ff;
         m2_valid_ff  <= m1_valid_ff;
         rsp_valid_ff <= m2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < AXES; a++) begin
            m1_idx_ff[a] <= (ex_multi_ff && ex_cnt_ff[a]) ? ex_nbr_ff[a] : ex_org_ff[a];
         end
         m1_nb_ff   <= ex_multi_ff ? ex_cnt_ff : '0;
         m1_last_ff <= !ex_multi_ff || (ex_cnt_ff == NB_LAST);

         m2_part_ff <= 20'(m1_idx_ff[2] * res_ff[1] + {11'd0, m1_idx_ff[1]});
         m2_x_ff    <= m1_idx_ff[0];
         m2_nb_ff   <= m1_nb_ff;
         m2_last_ff <= m1_last_ff;

         rsp_key_ff  <= KEY_W'(m2_part_ff * res_ff[0] + {21'd0, m2_x_ff});
         rsp_nb_ff   <= m2_nb_ff;
         rsp_last_ff <= m2_last_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_key             = rsp_key_ff;
   assign rsp_neighbor_number = rsp_nb_ff;
   assign rsp_last            = rsp_last_ff;

endmodule
